FILE: rtl/text_console_cell_writer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text console cell writer
// Shared property forms used by the modules that check themselves.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console cell writer package
// Types, character codes and helpers shared by the console modules.
// ----------------------------------------------------------------------------
package tccw_pkg;

	localparam int SCREEN_WIDTH_DEF  = 80;
	localparam int SCREEN_HEIGHT_DEF = 25;

	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int ADDR_W  = 11;
	localparam int BIN_W   = 32;
	localparam int DIGITS  = 10;
	localparam int BCD_W   = 4 * DIGITS;
	localparam int VALUE_W = 64;
	localparam int CNT_W   = $clog2(BIN_W);

	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_MINUS   = 8'h2d;

	typedef enum logic [1:0] {
		OP_CHAR = 2'd0,
		OP_DEC  = 2'd1,
		OP_HEX  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHAR,
		S_CONV,
		S_SIGN,
		S_PFX0,
		S_PFXX,
		S_DIGIT
	} state_t;

	typedef struct packed {
		logic emit;
		logic newline;
	} cur_cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic              off_screen;
	} cur_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} bcd_stat_t;

	// Maps a nibble to its lowercase hex character.
	function automatic logic [7:0] nib_char(input logic [3:0] nib);
		logic [7:0] wide;
		wide = {4'b0000, nib};
		if (nib >= 4'd10) begin
			return CH_LOWER_A + wide - 8'd10;
		end
		return CH_ZERO + wide;
	endfunction

endpackage

FILE: rtl/tccw_bcd_unit.sv
// ----------------------------------------------------------------------------
// Binary to BCD conversion unit
// Shift-and-add-three converter, one bit of the 32-bit magnitude per cycle.
// ----------------------------------------------------------------------------
module tccw_bcd_unit
	import tccw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [BIN_W-1:0] magnitude,
	output bcd_stat_t        stat,
	output logic [BCD_W-1:0] bcd
);

	logic [BIN_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [BCD_W-1:0] adj;

	// Every digit of five or more gets three added before the shift.
	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end else begin
				adj[4*d +: 4] = bcd_q[4*d +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(BIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= magnitude;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[BIN_W-1]};
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign bcd       = bcd_q;

endmodule

FILE: rtl/tccw_cursor.sv
// ----------------------------------------------------------------------------
// Text cursor
// Holds the cursor column and row and forms the cell address of the cursor.
// ----------------------------------------------------------------------------
module tccw_cursor
	import tccw_pkg::*;
#(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cur_cmd_t  cmd,
	output cur_stat_t stat
);

	localparam int PROD_W = ADDR_W + 1;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  row_next;
	logic [PROD_W-1:0] row_base;
	logic [PROD_W-1:0] addr_full;

	// The row stops at the first row past the screen.
	always_comb begin
		if (row_q < ROW_W'(SCREEN_HEIGHT)) begin
			row_next = row_q + 1'b1;
		end else begin
			row_next = row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			if (cmd.newline) begin
				col_q <= '0;
				row_q <= row_next;
			end else if (cmd.emit) begin
				if (col_q == COL_W'(SCREEN_WIDTH - 1)) begin
					col_q <= '0;
					row_q <= row_next;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	assign row_base  = PROD_W'(SCREEN_WIDTH) * PROD_W'(row_q);
	assign addr_full = row_base + PROD_W'(col_q);

	assign stat.address    = addr_full[ADDR_W-1:0];
	assign stat.off_screen = (row_q >= ROW_W'(SCREEN_HEIGHT));

endmodule

FILE: rtl/text_console_cell_writer.sv
// Sequencing: a character passes through the S_CHAR state, a hex print writes the prefix
// 0x and one cell per nibble, and a decimal print runs the BCD conversion, then writes a sign
// for a negative value and the digits; each cell is registered in the output register.
// A new request is taken in the cycle after the final cell is sent; a newline is taken
// while idle and leaves the sequencer idle. Output stalls hold the sequencer.
// Reset clears the cursor to column 0, row 0 and empties the output register.
// ----------------------------------------------------------------------------
// Text console cell writer
// Turns characters and numbers into text-cell writes at a moving cursor.
// ----------------------------------------------------------------------------
`include "text_console_cell_writer_defines.svh"

module text_console_cell_writer
	import tccw_pkg::*;
#(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // color [7:0], character [15:8], value [79:16]
	input  logic [1:0]  s_tuser,  // opcode [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // cell_address [10:0], cell_word [26:11], zero [31:27]
	output logic        m_tuser,  // off_screen [0]
	output logic        m_tlast
);

	state_t state_q, state_d;

	logic [VALUE_W-1:0] value_q;
	logic [7:0]         color_q;
	logic [7:0]         char_q;
	logic [3:0]         rem_q;
	logic               hex_q;
	logic               neg_q;
	logic               started_q;

	logic               accept;
	logic               out_free;
	logic               emit_req;
	logic               emit_fire;
	logic               emit_last;
	logic [7:0]         emit_char;
	logic               skip;
	logic               bcd_start;
	logic [3:0]         nib;

	op_t                in_op;
	logic [7:0]         in_color;
	logic [7:0]         in_char;
	logic [VALUE_W-1:0] in_value;
	logic [BIN_W-1:0]   in_low;
	logic [BIN_W-1:0]   in_mag;

	cur_cmd_t           cur_cmd;
	cur_stat_t          cur_stat;
	bcd_stat_t          bcd_stat;
	logic [BCD_W-1:0]   bcd;

	assign in_op    = op_t'(s_tuser);
	assign in_color = s_tdata[7:0];
	assign in_char  = s_tdata[15:8];
	assign in_value = s_tdata[79:16];
	assign in_low   = in_value[BIN_W-1:0];
	// Negation in unsigned arithmetic, so the most negative value works.
	assign in_mag   = in_low[BIN_W-1] ? (BIN_W'(0) - in_low) : in_low;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign emit_fire = emit_req && out_free;
	assign nib       = value_q[VALUE_W-1 -: 4];

	// Sequencer outputs.
	always_comb begin
		emit_req  = 1'b0;
		emit_last = 1'b0;
		emit_char = char_q;
		skip      = 1'b0;
		bcd_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				bcd_start = accept && (in_op == OP_DEC);
			end
			S_CHAR: begin
				emit_req  = 1'b1;
				emit_last = 1'b1;
			end
			S_CONV: begin
			end
			S_SIGN: begin
				emit_req  = 1'b1;
				emit_char = CH_MINUS;
			end
			S_PFX0: begin
				emit_req  = 1'b1;
				emit_char = CH_ZERO;
			end
			S_PFXX: begin
				emit_req  = 1'b1;
				emit_char = CH_LOWER_X;
			end
			S_DIGIT: begin
				// Leading zero digits of a decimal are dropped, all but the units.
				skip      = !hex_q && !started_q && (nib == 4'd0) && (rem_q != 4'd0);
				emit_req  = !skip;
				emit_last = (rem_q == 4'd0);
				emit_char = nib_char(nib);
			end
			default: begin
			end
		endcase
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority case (in_op)
						OP_CHAR: begin
							if (in_char != CH_NEWLINE) begin
								state_d = S_CHAR;
							end
						end
						OP_DEC:  state_d = S_CONV;
						OP_HEX:  state_d = S_PFX0;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_CHAR: begin
				if (emit_fire) begin
					state_d = S_IDLE;
				end
			end
			S_CONV: begin
				if (bcd_stat.done) begin
					state_d = neg_q ? S_SIGN : S_DIGIT;
				end
			end
			S_SIGN: begin
				if (emit_fire) begin
					state_d = S_DIGIT;
				end
			end
			S_PFX0: begin
				if (emit_fire) begin
					state_d = S_PFXX;
				end
			end
			S_PFXX: begin
				if (emit_fire) begin
					state_d = S_DIGIT;
				end
			end
			S_DIGIT: begin
				if (emit_fire && emit_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Item registers; the value register doubles as the digit shift line.
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q   <= in_value;
			color_q   <= in_color;
			char_q    <= in_char;
			hex_q     <= (in_op == OP_HEX);
			neg_q     <= in_low[BIN_W-1];
			started_q <= 1'b0;
			rem_q     <= (in_op == OP_HEX) ? 4'd15 : 4'(DIGITS - 1);
		end else if ((state_q == S_CONV) && bcd_stat.done) begin
			value_q <= {bcd, {(VALUE_W - BCD_W){1'b0}}};
		end else if ((state_q == S_DIGIT) && (skip || emit_fire)) begin
			value_q <= {value_q[VALUE_W-5:0], 4'b0000};
			rem_q   <= rem_q - 1'b1;
			if (emit_fire) begin
				started_q <= 1'b1;
			end
		end
	end

	assign cur_cmd.emit    = emit_fire;
	assign cur_cmd.newline = accept && (in_op == OP_CHAR) && (in_char == CH_NEWLINE);

	tccw_cursor #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cur_cmd),
		.stat   (cur_stat)
	);

	tccw_bcd_unit u_bcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (bcd_start),
		.magnitude (in_mag),
		.stat      (bcd_stat),
		.bcd       (bcd)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_tdata <= {5'b00000, color_q, emit_char, cur_stat.address};
			m_tuser <= cur_stat.off_screen;
			m_tlast <= emit_last;
		end
	end

	// A cell flagged off screen means the row has saturated, and it never leaves.
	`TCCW_ASSERT_SAME(a_offscreen_row, clk, arst_n, m_tvalid && m_tuser, cur_stat.off_screen, "off-screen cell while cursor is on screen")
	`TCCW_ASSERT_SAME(a_bcd_done_conv, clk, arst_n, bcd_stat.done, state_q == S_CONV, "BCD result outside the conversion state")
	`TCCW_ASSERT_NEXT(a_last_to_idle, clk, arst_n, emit_fire && emit_last, state_q == S_IDLE, "sequencer busy after the final cell of a request")
	`TCCW_ASSERT_SAME(a_busy_not_idle, clk, arst_n, bcd_stat.busy, !s_tready, "input ready during decimal conversion")

endmodule
